### design/layer_norm_row_core_macros.svh
// ----------------------------------------------------------------------------
// Layer normalisation row core assertion macros
// Shared assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef LAYER_NORM_ROW_CORE_MACROS_SVH
`define LAYER_NORM_ROW_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LNR_ASSERT_NOW(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define LNR_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define LNR_ASSERT_NEXT_ALWAYS(label, clk, a, c) \
  label: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("assertion failed");

`endif

### design/lnr_pkg.sv
// ----------------------------------------------------------------------------
// Layer normalisation row package
// Widths, constants and status types shared by the row core and its units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lnr_pkg;

  localparam int MAX_COLS = 64;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int DVD_W    = 51;
  localparam int DVS_W    = 32;
  localparam int RAD_W    = 50;
  localparam int ROOT_W   = 25;
  localparam int EPS_Q24  = 168;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

`default_nettype wire

### design/lnr_div.sv
// ----------------------------------------------------------------------------
// Layer normalisation restoring divider
// Unsigned divider that resolves one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lnr_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [lnr_pkg::DVD_W-1:0] dividend,
  input  wire logic [lnr_pkg::DVS_W-1:0] divisor,
  output logic [lnr_pkg::DVD_W-1:0]      quotient,
  output lnr_pkg::unit_status_t          status
);
  import lnr_pkg::*;

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [5:0]       steps;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W+1:0] diff;

  assign rem_sh = {rem, quotient[DVD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      steps  <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        quotient    <= dividend;
        dvs         <= divisor;
        rem         <= '0;
        steps       <= 6'(DVD_W);
        status.busy <= 1'b1;
      end else if (status.busy) begin
        if (!diff[DVS_W+1]) begin
          rem      <= diff[DVS_W-1:0];
          quotient <= {quotient[DVD_W-2:0], 1'b1};
        end else begin
          rem      <= rem_sh[DVS_W-1:0];
          quotient <= {quotient[DVD_W-2:0], 1'b0};
        end
        steps <= steps - 6'd1;
        if (steps == 6'd1) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### design/lnr_sqrt.sv
// ----------------------------------------------------------------------------
// Layer normalisation square root unit
// Floored integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lnr_sqrt (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [lnr_pkg::RAD_W-1:0] radicand,
  output logic [lnr_pkg::ROOT_W-1:0]     root,
  output lnr_pkg::unit_status_t          status
);
  import lnr_pkg::*;

  logic [RAD_W-1:0]  rad;
  logic [ROOT_W+1:0] rem;
  logic [4:0]        steps;
  logic [ROOT_W+3:0] rem_sh;
  logic [ROOT_W+3:0] trial;
  logic [ROOT_W+4:0] diff;

  assign rem_sh = {rem, rad[RAD_W-1:RAD_W-2]};
  assign trial  = {2'b00, root, 2'b01};
  assign diff   = {1'b0, rem_sh} - {1'b0, trial};

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      steps  <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        rad         <= radicand;
        rem         <= '0;
        root        <= '0;
        steps       <= 5'(ROOT_W);
        status.busy <= 1'b1;
      end else if (status.busy) begin
        rad <= {rad[RAD_W-3:0], 2'b00};
        if (!diff[ROOT_W+4]) begin
          rem  <= diff[ROOT_W+1:0];
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh[ROOT_W+1:0];
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        steps <= steps - 5'd1;
        if (steps == 5'd1) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### design/layer_norm_row_core.sv
// ----------------------------------------------------------------------------
// Layer normalisation row core
// Stores a row of Q4.12 samples, then emits each sample normalised by the
// row mean and standard deviation, using one shared multiplier, a shared
// divider and a square root unit under a sequencer.
//
//   Channel  Handshake            Payload
//   in       in_valid, in_stall   sample, row_end
//   out      out_valid, out_stall normalized, final_res
//
// Loading accepts one sample per cycle while in_stall is low. At the row
// close, a squares pass over the stored samples runs, then the variance
// divide and the root; each result is then formed by the 51-step divider.
// in_stall is high from the row close until the last result transfer; a
// stalled result holds the sequencer. Reset is synchronous and clears the
// count and running total; the sample store needs no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module layer_norm_row_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] sample,
  input  wire logic               row_end,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      normalized,
  output logic                    final_res
);
  import lnr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ_RD, S_SQ_NX, S_SQ_E, S_SQ_MUL, S_SQ_ACC, S_NN, S_NNN,
    S_VDIV, S_VWAIT, S_ROOT, S_RWAIT, S_DEN, S_DEN2, S_NM_RD, S_NM_NX,
    S_NM_E, S_NM_DIV, S_NM_WAIT, S_EMIT
  } state_t;

  state_t state;

  logic signed [15:0] mem [MAX_COLS];
  logic signed [15:0] rd_data;
  logic [CNT_W-1:0]   cnt;
  logic [IDX_W-1:0]   idx;
  logic signed [21:0] total;
  logic signed [24:0] e;
  logic [50:0]        sq;
  logic [31:0]        den;
  logic signed [51:0] prod;
  logic signed [25:0] mul_a;
  logic signed [25:0] mul_b;
  logic [23:0]        e_abs;
  logic [24:0]        e_next;
  logic               in_xfer;
  logic               idx_last;
  logic               div_start;
  logic               root_start;
  logic [DVD_W-1:0]   div_dvd;
  logic [DVS_W-1:0]   div_dvs;
  logic [DVD_W-1:0]   div_quo;
  logic [ROOT_W-1:0]  sd;
  logic [33:0]        var_eps;
  unit_status_t       div_st;
  unit_status_t       root_st;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign idx_last = ({1'b0, idx} == (cnt - 7'd1));
  assign e_next   = prod[24:0] - {{3{total[21]}}, total};
  assign e_abs    = e[24] ? 24'(-e) : e[23:0];
  assign var_eps  = {1'b0, div_quo[32:0]} + 34'(EPS_Q24);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQ_NX, S_NM_NX: begin
        mul_a = $signed({19'b0, cnt});
        mul_b = {{10{rd_data[15]}}, rd_data};
      end
      S_SQ_MUL: begin
        mul_a = {e[24], e};
        mul_b = {e[24], e};
      end
      S_NN: begin
        mul_a = $signed({19'b0, cnt});
        mul_b = $signed({19'b0, cnt});
      end
      S_NNN: begin
        mul_a = prod[25:0];
        mul_b = $signed({19'b0, cnt});
      end
      S_DEN: begin
        mul_a = $signed({19'b0, cnt});
        mul_b = $signed({1'b0, sd});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (state)
      S_VDIV: begin
        div_start = 1'b1;
        div_dvd   = sq;
        div_dvs   = prod[31:0];
      end
      S_NM_DIV: begin
        div_start = 1'b1;
        div_dvd   = {7'b0, e_abs, 20'b0} + {20'b0, den[31:1]};
        div_dvs   = den;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign root_start = (state == S_ROOT);

  lnr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_quo),
    .status   (div_st)
  );

  lnr_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand ({var_eps, 16'b0}),
    .root     (sd),
    .status   (root_st)
  );

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mem[cnt[IDX_W-1:0]] <= sample;
    end
    rd_data <= mem[idx];
    prod    <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      total     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            cnt   <= cnt + 7'd1;
            total <= total + 22'(sample);
            if (row_end || cnt == 7'(MAX_COLS - 1)) begin
              idx   <= '0;
              sq    <= '0;
              state <= S_SQ_RD;
            end
          end
        end
        S_SQ_RD:  state <= S_SQ_NX;
        S_SQ_NX:  state <= S_SQ_E;
        S_SQ_E: begin
          e     <= e_next;
          state <= S_SQ_MUL;
        end
        S_SQ_MUL: state <= S_SQ_ACC;
        S_SQ_ACC: begin
          sq <= sq + prod[50:0];
          if (idx_last) begin
            state <= S_NN;
          end else begin
            idx   <= idx + 6'd1;
            state <= S_SQ_RD;
          end
        end
        S_NN:     state <= S_NNN;
        S_NNN:    state <= S_VDIV;
        S_VDIV:   state <= S_VWAIT;
        S_VWAIT: begin
          if (div_st.done) begin
            state <= S_ROOT;
          end
        end
        S_ROOT:   state <= S_RWAIT;
        S_RWAIT: begin
          if (root_st.done) begin
            state <= S_DEN;
          end
        end
        S_DEN:    state <= S_DEN2;
        S_DEN2: begin
          den   <= prod[31:0];
          idx   <= '0;
          state <= S_NM_RD;
        end
        S_NM_RD:  state <= S_NM_NX;
        S_NM_NX:  state <= S_NM_E;
        S_NM_E: begin
          e     <= e_next;
          state <= S_NM_DIV;
        end
        S_NM_DIV: state <= S_NM_WAIT;
        S_NM_WAIT: begin
          if (div_st.done) begin
            if (!e[24]) begin
              normalized <= (div_quo > 51'd32767) ? 16'sd32767 : $signed(div_quo[15:0]);
            end else begin
              normalized <= (div_quo >= 51'd32768) ? -16'sd32768
                                                   : $signed(16'(-div_quo[15:0]));
            end
            final_res <= idx_last;
            out_valid <= 1'b1;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (final_res) begin
              cnt   <= '0;
              total <= '0;
              state <= S_IDLE;
            end else begin
              idx   <= idx + 6'd1;
              state <= S_NM_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/layer_norm_row_core_checker.sv
// ----------------------------------------------------------------------------
// Layer normalisation row core checker
// Port-level assertions on the row core, attached by a bind statement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "layer_norm_row_core_macros.svh"

module layer_norm_row_core_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        row_end,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] normalized,
  input wire logic        final_res
);

  `LNR_ASSERT_NOW(a_busy_while_out, clk, rst, out_valid, in_stall)
  `LNR_ASSERT_NEXT(a_close_stalls, clk, rst, in_valid && !in_stall && row_end, in_stall)
  `LNR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
                   out_valid && $stable(normalized) && $stable(final_res))
  `LNR_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, !out_valid && !in_stall)

endmodule

bind layer_norm_row_core layer_norm_row_core_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .row_end    (row_end),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .normalized (normalized),
  .final_res  (final_res)
);

`default_nettype wire

### test/tb_layer_norm_row_core.sv
// ----------------------------------------------------------------------------
// Layer normalisation row core testbench
// Sends rows of Q4.12 samples under varying idle and stall patterns and
// checks every normalised result against an integer model of the row maths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_layer_norm_row_core;
  import lnr_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct {
    logic signed [15:0] value;
    logic               last;
  } norm_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] sample = '0;
  logic row_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] normalized;
  logic final_res;

  logic signed [15:0] held_row [MAX_COLS];
  int                 held_count = 0;
  norm_result_t       expected_norm [$];
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 errors = 0;
  int                 rows_closed = 0;
  int                 results_seen = 0;
  int                 idle_cycles = 0;

  layer_norm_row_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample(sample), .row_end(row_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .normalized(normalized), .final_res(final_res)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic normalise_row();
    longint n;
    longint tot;
    longint e;
    longint unsigned m;
    longint unsigned sq;
    longint unsigned sd;
    longint unsigned den;
    longint unsigned q;
    longint y;
    norm_result_t r;
    n = held_count;
    tot = 0;
    sq = 0;
    for (int i = 0; i < n; i++) tot += held_row[i];
    for (int i = 0; i < n; i++) begin
      e = n * held_row[i] - tot;
      m = (e < 0) ? -e : e;
      sq += m * m;
    end
    sd = isqrt(((sq / (n * n * n)) + EPS_Q24) << 16);
    den = n * sd;
    for (int i = 0; i < n; i++) begin
      e = n * held_row[i] - tot;
      m = ((e < 0) ? -e : e);
      q = ((m << 20) + den / 2) / den;
      if (q > 65536) q = 65536;
      y = (e < 0) ? -longint'(q) : longint'(q);
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      r.value = 16'(y);
      r.last = (i == n - 1);
      expected_norm.push_back(r);
    end
    held_count = 0;
    rows_closed++;
  endtask

  task automatic send_sample(input logic signed [15:0] s, input logic e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      sample <= 16'($urandom);
      row_end <= 1'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    row_end <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    held_row[held_count] = s;
    held_count++;
    if (e || held_count == MAX_COLS) normalise_row();
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_norm.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %0d/%0b", $time, normalized, final_res);
        end else begin
          norm_result_t x;
          x = expected_norm.pop_front();
          if (x.value !== normalized || x.last !== final_res) begin
            errors++;
            $display("%0t: expected %0d/%0b actual %0d/%0b", $time, x.value, x.last,
                     normalized, final_res);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_row(input int len, input int mode);
    logic signed [15:0] s;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: s = 16'($urandom);
        1: s = 16'($signed($urandom_range(400)) - 200);
        default: s = (i % 2) ? 16'sh7fff : -16'sh8000;
      endcase
      send_sample(s, i == len - 1);
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_norm.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_sample(16'sh7fff, 1'b1);
    send_sample(-16'sh8000, 1'b1);
    for (int i = 0; i < 4; i++) send_sample(16'sh1234, i == 3);
    send_row(2, 2);
    send_sample(16'sh0001, 1'b0);
    send_sample(16'sh0000, 1'b1);
    send_row(3, 0);
    send_row(4, 1);
    wait_drain();
  endtask

  task automatic test_full_row();
    for (int i = 0; i < MAX_COLS; i++) send_sample(16'($urandom), 1'b0);
    wait_drain();
  endtask

  task automatic test_random(input int idle, input int stall, input int items);
    int sent;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < items) begin
      int len;
      len = $urandom_range(8, 1);
      send_row(len, $urandom_range(2));
      sent += len;
    end
    wait_drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_row();
    test_random(0, 0, 10);
    test_random(49, 0, 10);
    test_random(0, 49, 10);
    test_random(22, 22, 10);
    recv_stall_pct = 0;
    repeat (200) @(posedge clk);
    $display("Covered %0d rows and %0d results, including a full row and flat rows,",
             rows_closed, results_seen);
    $display("under sender idling and receiver stalling.");
    if (errors == 0 && expected_norm.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
